// ===== src/smith_waterman_stats_cell_assert.svh =====
// Assertion macros for the Smith-Waterman statistics cell.
`ifndef SMITH_WATERMAN_STATS_CELL_ASSERT_SVH
`define SMITH_WATERMAN_STATS_CELL_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SWSC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SWSC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/swsc_pkg.sv =====
// Shared constants, types and helper functions of the Smith-Waterman statistics cell.
package swsc_pkg;

	localparam int QUERY_MAX = 256;
	localparam int REF_MAX   = 65536;

	localparam int QIDX_W = $clog2(QUERY_MAX);
	localparam int QLEN_W = $clog2(QUERY_MAX + 1);
	localparam int REF_W  = $clog2(REF_MAX);

	localparam int GAP_W  = 7;
	localparam int CFG_W  = 9;
	localparam int CIDX_W = 2;

	localparam logic [CIDX_W-1:0] REG_GAP_OPEN     = CIDX_W'(0);
	localparam logic [CIDX_W-1:0] REG_GAP_EXTEND   = CIDX_W'(1);
	localparam logic [CIDX_W-1:0] REG_QUERY_LENGTH = CIDX_W'(2);

	localparam logic [GAP_W-1:0]  GAP_OPEN_RST   = GAP_W'(10);
	localparam logic [GAP_W-1:0]  GAP_EXTEND_RST = GAP_W'(1);
	localparam logic [QLEN_W-1:0] QLEN_RST       = QLEN_W'(256);
	localparam logic [QLEN_W-1:0] QLEN_CAP       = QLEN_W'(QUERY_MAX);
	localparam logic [REF_W-1:0]  COL_LAST       = REF_W'(REF_MAX - 1);

	localparam logic [7:0] SAT8 = 8'hFF;

	// Score and statistics of one cell
	typedef struct packed {
		logic [7:0] h;
		logic [7:0] m;
		logic [7:0] s;
		logic [7:0] l;
	} stats_t;

	// One row of the column store
	typedef struct packed {
		logic [7:0] h;
		logic [7:0] e;
		logic [7:0] m;
		logic [7:0] s;
		logic [7:0] l;
	} store_t;

	localparam int STORE_W = $bits(store_t);

	typedef struct packed {
		logic signed [7:0] sub_score;
		logic              is_match;
		logic              is_similar;
		stats_t            old;
		logic [7:0]        e;
		stats_t            diag;
		stats_t            above;
		logic [7:0]        f;
	} cell_in_t;

	typedef struct packed {
		stats_t     c;
		logic [7:0] ne;
		logic [7:0] nf;
		logic       sat;
	} cell_out_t;

	typedef struct packed {
		logic              saturated;
		logic [REF_W-1:0]  end_ref;
		logic [QLEN_W-1:0] end_row;
		logic [7:0]        align_length;
		logic [7:0]        similar_count;
		logic [7:0]        match_count;
		logic [7:0]        best_score;
	} result_t;

	function automatic logic [7:0] sat_inc(input logic [7:0] x, input logic b);
		logic [8:0] t;
		t = {1'b0, x} + {8'b0, b};
		return t[8] ? SAT8 : t[7:0];
	endfunction

	function automatic logic [7:0] sub_sat(input logic [7:0] a, input logic [GAP_W-1:0] b);
		logic [7:0] bx;
		bx = {1'b0, b};
		return (a > bx) ? (a - bx) : 8'd0;
	endfunction

	function automatic logic [7:0] max8(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage

// ===== src/swsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module swsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/swsc_cell.sv =====
// Affine-gap recurrence and statistics update for one DP cell.
module swsc_cell import swsc_pkg::*; (
	input  cell_in_t         cin,
	input  logic [GAP_W-1:0] gap_open,
	input  logic [GAP_W-1:0] gap_extend,
	output cell_out_t        cout
);

	logic signed [9:0] dsum;
	logic [7:0]        d;
	logic [7:0]        h;
	logic              c1not;
	logic              f_wins;
	logic [7:0]        hopen;
	stats_t            c;

	always_comb begin
		dsum = $signed({2'b00, cin.diag.h}) + $signed({{2{cin.sub_score[7]}}, cin.sub_score});
		if (dsum[9]) begin
			d = 8'd0;
		end else if (dsum[8]) begin
			d = SAT8;
		end else begin
			d = dsum[7:0];
		end

		c1not  = (d < cin.f) || (d < cin.e);
		f_wins = !(cin.f < cin.e);
		h      = max8(max8(d, cin.e), cin.f);

		c.h = h;
		if (!c1not) begin
			c.m = sat_inc(cin.diag.m, cin.is_match);
			c.s = sat_inc(cin.diag.s, cin.is_similar);
			c.l = sat_inc(cin.diag.l, 1'b1);
		end else if (f_wins) begin
			c.m = cin.above.m;
			c.s = cin.above.s;
			c.l = sat_inc(cin.above.l, 1'b1);
		end else begin
			c.m = cin.old.m;
			c.s = cin.old.s;
			c.l = sat_inc(cin.old.l, 1'b1);
		end
		// an empty cell starts no alignment
		if (h == 8'd0) begin
			c.m = 8'd0;
			c.s = 8'd0;
			c.l = 8'd0;
		end

		hopen    = sub_sat(h, gap_open);
		cout.c   = c;
		cout.ne  = max8(sub_sat(cin.e, gap_extend), hopen);
		cout.nf  = max8(sub_sat(cin.f, gap_extend), hopen);
		cout.sat = (c.h == SAT8) || (c.m == SAT8) || (c.s == SAT8) || (c.l == SAT8);
	end

endmodule

// ===== src/smith_waterman_stats_cell.sv =====
// Top level of the Smith-Waterman local alignment cell engine with statistics.
//
// Local alignment with affine gaps, one DP cell per item, query-major within
// each reference column. The block sustains one item per clock while s_tready
// is high: the row counter picks the column-store address as an item is taken,
// the store read returns in the next cycle, and the whole cell recurrence plus
// best-cell tracking runs in that one stage (s1) with the store written back
// at its end. A row read in the same cycle that it is being written (query
// length of one) is served from a forwarding register. A result is formed in
// s1 from the item carrying tlast and goes into a two-entry output buffer;
// s_tready only drops while both entries are (or are about to be) occupied by
// unread results, so a stalled consumer costs input cycles only once two
// results are waiting. The column store needs no clearing pass: the first
// column reads as zero by construction. Gap and query length registers are to
// be written on the cfg port while the block is idle, which it does not enforce.
`include "smith_waterman_stats_cell_assert.svh"
module smith_waterman_stats_cell import swsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// cell items
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,  // [7:0] sub_score, [8] is_match, [9] is_similar
	input  logic              s_tlast,  // last_cell
	// result items
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [63:0]       m_tdata,  // best_score, match_count, similar_count,
	                                    // align_length, end_row, end_ref, saturated
	// configuration writes
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	// configuration
	logic [GAP_W-1:0]  gap_open_q;
	logic [GAP_W-1:0]  gap_extend_q;
	logic [QLEN_W-1:0] qlen_q;
	logic [QLEN_W-1:0] qlen_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_open_q   <= GAP_OPEN_RST;
			gap_extend_q <= GAP_EXTEND_RST;
			qlen_q       <= QLEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAP_OPEN:     gap_open_q   <= cfg_data[GAP_W-1:0];
				REG_GAP_EXTEND:   gap_extend_q <= cfg_data[GAP_W-1:0];
				REG_QUERY_LENGTH: qlen_q       <= cfg_data[QLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, anything beyond the store depth as the full depth
	always_comb begin
		if (qlen_q == '0) begin
			qlen_eff = QLEN_W'(1);
		end else if (qlen_q > QLEN_CAP) begin
			qlen_eff = QLEN_CAP;
		end else begin
			qlen_eff = qlen_q;
		end
	end

	// input side: row/column sequencer
	logic              accept;
	logic [QIDX_W-1:0] row_q;
	logic [REF_W-1:0]  col_q;
	logic [QLEN_W-1:0] row_next;
	logic              col_end;

	assign accept   = s_tvalid && s_tready;
	assign row_next = {1'b0, row_q} + QLEN_W'(1);
	assign col_end  = s_tlast || (row_next >= qlen_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				row_q <= '0;
				col_q <= '0;
			end else if (col_end) begin
				row_q <= '0;
				if (col_q != COL_LAST) begin
					col_q <= col_q + REF_W'(1);
				end
			end else begin
				row_q <= row_next[QIDX_W-1:0];
			end
		end
	end

	// stage 1 item register
	logic              valid_s1;
	logic signed [7:0] sub_s1;
	logic              match_s1;
	logic              sim_s1;
	logic              last_s1;
	logic              fin_s1;
	logic              colz_s1;
	logic [QIDX_W-1:0] row_s1;
	logic [REF_W-1:0]  col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				last_s1 <= s_tlast;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sub_s1   <= s_tdata[7:0];
			match_s1 <= s_tdata[8];
			sim_s1   <= s_tdata[9];
			fin_s1   <= col_end;
			colz_s1  <= (col_q == '0);
			row_s1   <= row_q;
			col_s1   <= col_q;
		end
	end

	// column store and write-to-read forwarding
	store_t ram_rdata;
	store_t wr_data;
	store_t fwd_q;
	logic   fwd_hit_q;
	store_t stored;

	swsc_ram #(
		.WIDTH(STORE_W),
		.DEPTH(QUERY_MAX)
	) u_store (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(row_s1),
		.wdata(wr_data),
		.re   (accept),
		.raddr(row_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else if (accept) begin
			fwd_hit_q <= valid_s1 && (row_s1 == row_q);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_q <= wr_data;
		end
	end

	assign stored = fwd_hit_q ? fwd_q : ram_rdata;

	// cell recurrence
	stats_t    diag_q;
	stats_t    above_q;
	logic [7:0] vgap_q;
	cell_in_t  cin;
	cell_out_t cout;

	always_comb begin
		cin.sub_score  = sub_s1;
		cin.is_match   = match_s1;
		cin.is_similar = sim_s1;
		// first column: previous column is all zero
		if (colz_s1) begin
			cin.old = '0;
			cin.e   = 8'd0;
		end else begin
			cin.old = '{h: stored.h, m: stored.m, s: stored.s, l: stored.l};
			cin.e   = stored.e;
		end
		// first row: nothing above or on the diagonal
		if (row_s1 == '0) begin
			cin.diag  = '0;
			cin.above = '0;
			cin.f     = 8'd0;
		end else begin
			cin.diag  = diag_q;
			cin.above = above_q;
			cin.f     = vgap_q;
		end
	end

	swsc_cell u_cell (
		.cin       (cin),
		.gap_open  (gap_open_q),
		.gap_extend(gap_extend_q),
		.cout      (cout)
	);

	assign wr_data = '{h: cout.c.h, e: cout.ne, m: cout.c.m, s: cout.c.s, l: cout.c.l};

	// best of the column, then best overall at each column end
	stats_t            cb_q;
	logic [QIDX_W-1:0] cb_row_q;
	stats_t            best_q;
	logic [QIDX_W-1:0] best_row_q;
	logic [REF_W-1:0]  best_col_q;
	logic              sat_q;

	stats_t            cb_now;
	logic [QIDX_W-1:0] cb_row_now;
	stats_t            best_now;
	logic [QIDX_W-1:0] best_row_now;
	logic [REF_W-1:0]  best_col_now;
	logic              res_sat;
	result_t           res;

	always_comb begin
		if (cout.c.h > cb_q.h) begin
			cb_now     = cout.c;
			cb_row_now = row_s1;
		end else begin
			cb_now     = cb_q;
			cb_row_now = cb_row_q;
		end
		if (cb_now.h > best_q.h) begin
			best_now     = cb_now;
			best_row_now = cb_row_now;
			best_col_now = col_s1;
		end else begin
			best_now     = best_q;
			best_row_now = best_row_q;
			best_col_now = best_col_q;
		end

		// a last cell always closes its column, so best_now is final here
		res_sat           = sat_q || cout.sat || (best_now.h == SAT8);
		res.saturated     = res_sat;
		res.best_score    = res_sat ? SAT8 : best_now.h;
		res.match_count   = res_sat ? 8'd0 : best_now.m;
		res.similar_count = res_sat ? 8'd0 : best_now.s;
		res.align_length  = res_sat ? 8'd0 : best_now.l;
		res.end_row       = (best_now.h == 8'd0) ? qlen_eff : {1'b0, best_row_now};
		res.end_ref       = (best_now.h == 8'd0) ? '0 : best_col_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diag_q     <= '0;
			above_q    <= '0;
			vgap_q     <= 8'd0;
			cb_q       <= '0;
			cb_row_q   <= '0;
			best_q     <= '0;
			best_row_q <= '0;
			best_col_q <= '0;
			sat_q      <= 1'b0;
		end else if (valid_s1) begin
			diag_q  <= cin.old;
			above_q <= cout.c;
			vgap_q  <= cout.nf;
			if (last_s1) begin
				// alignment done: start the next one clean
				cb_q       <= '0;
				cb_row_q   <= '0;
				best_q     <= '0;
				best_row_q <= '0;
				best_col_q <= '0;
				sat_q      <= 1'b0;
			end else begin
				sat_q <= sat_q || cout.sat;
				if (fin_s1) begin
					cb_q       <= '0;
					cb_row_q   <= '0;
					best_q     <= best_now;
					best_row_q <= best_row_now;
					best_col_q <= best_col_now;
				end else begin
					cb_q     <= cb_now;
					cb_row_q <= cb_row_now;
				end
			end
		end
	end

	// two-entry output buffer: head drives the port, skid catches a second result
	logic    push;
	logic    pop;
	logic    o_valid_q;
	logic    k_valid_q;
	result_t o_q;
	result_t k_q;

	assign push = valid_s1 && last_s1;
	assign pop  = o_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
			k_valid_q <= 1'b0;
		end else if (pop) begin
			if (k_valid_q) begin
				k_valid_q <= push;
			end else begin
				o_valid_q <= push;
			end
		end else if (push) begin
			if (o_valid_q) begin
				k_valid_q <= 1'b1;
			end else begin
				o_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (k_valid_q) begin
				o_q <= k_q;
				if (push) begin
					k_q <= res;
				end
			end else if (push) begin
				o_q <= res;
			end
		end else if (push) begin
			if (o_valid_q) begin
				k_q <= res;
			end else begin
				o_q <= res;
			end
		end
	end

	// an item taken now may need a slot once it has passed s1; a head being read
	// this cycle frees its slot for the result about to arrive
	assign s_tready = !(k_valid_q || (o_valid_q && valid_s1 && last_s1 && !m_tready));
	assign m_tvalid = o_valid_q;
	assign m_tdata  = {6'b0, o_q};

	// checks
	`SWSC_ASSERT_IMP(a_no_overflow, push && k_valid_q, pop, "result buffer overflow")
	`SWSC_ASSERT_IMP(a_skid_order, k_valid_q, o_valid_q, "skid entry without head entry")
	`SWSC_ASSERT_NXT(a_result_out, push, m_tvalid, "last cell gave no result")

endmodule
